[design/assert_macros.svh]
// Assertion helpers shared by the checking code of the design.
// Every check is sampled on the rising clock edge; ASSERT_CLK skips reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked concurrent assertion, disabled while reset is low.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked concurrent assertion, also checked while reset is low.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[design/imu_cal_pkg.sv]
// ----------------------------------------------------------------------------
// IMU calibration package
// Widths, codes, shared types and the run-length helper for the bias
// averaging block.
// ----------------------------------------------------------------------------
package imu_cal_pkg;

    localparam int COUNT_BITS = 16;
    localparam int CFG_W      = 16;
    localparam int DATA_W     = 16;
    localparam int AXES       = 6;
    localparam int SUM_W      = DATA_W + 1 + COUNT_BITS;
    localparam int STEP_W     = $clog2(SUM_W);
    localparam int CMP_W      = (CFG_W > COUNT_BITS) ? CFG_W : COUNT_BITS;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(10);

    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_FAILED = 1'b1;

    // One axis value per lane.
    typedef logic signed [DATA_W-1:0] t_axis_vec [AXES];

    // Per-lane control, driven by the sequencer in the top level.
    typedef struct packed {
        logic add;
        logic clear;
        logic start;
        logic step;
    } t_lane_ctl;

    // Load request into the result register.
    typedef struct packed {
        logic load;
        logic status;
    } t_merge_ctl;

    // Run length: zero acts as one, values above the counter range saturate.
    function automatic logic [COUNT_BITS-1:0] eff_count(input logic [CFG_W-1:0] cfg);
        logic [CMP_W-1:0] n;
        logic [CMP_W-1:0] cap;
        n   = CMP_W'(cfg);
        cap = CMP_W'((64'd1 << COUNT_BITS) - 64'd1);
        if (n == '0) begin
            n = CMP_W'(1);
        end
        if (n > cap) begin
            n = cap;
        end
        return COUNT_BITS'(n);
    endfunction

endpackage

[design/imu_cal_lane.sv]
// ----------------------------------------------------------------------------
// IMU calibration lane
// Accumulates one axis and divides the finished sum by the sample count
// with a restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module imu_cal_lane (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  imu_cal_pkg::t_lane_ctl               i_ctl,
    input  logic signed [imu_cal_pkg::DATA_W-1:0] i_sample,
    input  logic [imu_cal_pkg::COUNT_BITS-1:0]   i_divisor,
    output logic signed [imu_cal_pkg::DATA_W-1:0] o_bias
);
    import imu_cal_pkg::*;

    logic signed [SUM_W-1:0]      r_sum;
    logic [SUM_W-1:0]             r_quo;
    logic [COUNT_BITS-1:0]        r_rem;
    logic                         r_neg;

    logic signed [SUM_W-1:0]      sum_total;
    logic [SUM_W-1:0]             sum_u;
    logic [SUM_W-1:0]             mag;
    logic [COUNT_BITS:0]          trial;
    logic [COUNT_BITS:0]          div_ext;
    logic                         fit;
    logic [COUNT_BITS-1:0]        n_rem;
    logic signed [DATA_W-1:0]     quo_low;

    // Running sum including the sample at the inputs.
    assign sum_total = r_sum + SUM_W'(i_sample);
    assign sum_u     = $unsigned(sum_total);
    assign mag       = sum_total[SUM_W-1] ? (~sum_u + 1'b1) : sum_u;

    // One restoring division step.
    assign trial   = {r_rem, r_quo[SUM_W-1]};
    assign div_ext = {1'b0, i_divisor};
    assign fit     = (trial >= div_ext);
    assign n_rem   = fit ? COUNT_BITS'(trial - div_ext) : trial[COUNT_BITS-1:0];

    // Accumulator: cleared on abort and when a run hands its sum to the divider.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_ctl.clear || i_ctl.start) begin
            r_sum <= '0;
        end else if (i_ctl.add) begin
            r_sum <= sum_total;
        end
    end

    // Divider works on the magnitude; the sign is put back at the end.
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_quo <= mag;
            r_rem <= '0;
            r_neg <= sum_total[SUM_W-1];
        end else if (i_ctl.step) begin
            r_quo <= {r_quo[SUM_W-2:0], fit};
            r_rem <= n_rem;
        end
    end

    // The mean always fits the sample width, so the low bits carry it.
    assign quo_low = $signed(r_quo[DATA_W-1:0]);
    assign o_bias  = r_neg ? -quo_low : quo_low;

endmodule

[design/imu_cal_merge.sv]
// ----------------------------------------------------------------------------
// IMU calibration result merge
// Collects the six lane biases and the status into one result item and
// holds it until the receiver takes it.
// ----------------------------------------------------------------------------
module imu_cal_merge (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  imu_cal_pkg::t_merge_ctl i_ctl,
    input  imu_cal_pkg::t_axis_vec i_bias,
    input  logic                   i_out_ready,
    output logic                   o_out_valid,
    output imu_cal_pkg::t_axis_vec o_bias,
    output logic                   o_status
);
    import imu_cal_pkg::*;

    logic      r_valid;
    t_axis_vec r_bias;
    logic      r_status;

    // Valid flag of the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Payload: an aborted run reports zero biases.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_status <= i_ctl.status;
            for (int i = 0; i < AXES; i++) begin
                r_bias[i] <= (i_ctl.status == STATUS_FAILED) ? '0 : i_bias[i];
            end
        end
    end

    assign o_out_valid = r_valid;
    assign o_bias      = r_bias;
    assign o_status    = r_status;

endmodule

[design/imu_bias_average_calibration.sv]
// ----------------------------------------------------------------------------
// IMU bias averaging calibration
// Averages six-axis inertial samples over a configured run length.
// ----------------------------------------------------------------------------
// Usage:
// - Input channel (i_in_valid / o_in_ready): one six-axis sample per item with
//   a read-failure flag. A sample that only accumulates is taken while idle.
// - Output channel (o_out_valid / i_out_ready): one result item per finished
//   or aborted run, held in an output register until the receiver takes it.
// - Configuration channel (i_cfg_valid / o_cfg_ready): run length, always
//   ready; write it only while no item is in flight. A new length applies
//   from the next sample, also in the middle of a run.
// - The item that completes a run starts six lanes that divide in parallel,
//   one quotient bit per cycle; the result is loaded into the output register
//   when the divide steps end and it is empty; the input waits until then.
// - A failed read yields a result with status failed in the next cycle and
//   restarts the run.
// - While a result waits in the output register, samples that produce no
//   result are still taken; one that would produce a result waits.
// - Reset clears the sums, the sample counter and the output valid flag and
//   sets the run length to 10. No clearing pass is needed.
// ----------------------------------------------------------------------------
module imu_bias_average_calibration (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic signed [imu_cal_pkg::DATA_W-1:0] i_accel_x,
    input  logic signed [imu_cal_pkg::DATA_W-1:0] i_accel_y,
    input  logic signed [imu_cal_pkg::DATA_W-1:0] i_accel_z,
    input  logic signed [imu_cal_pkg::DATA_W-1:0] i_gyro_x,
    input  logic signed [imu_cal_pkg::DATA_W-1:0] i_gyro_y,
    input  logic signed [imu_cal_pkg::DATA_W-1:0] i_gyro_z,
    input  logic                                  i_read_failed,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [imu_cal_pkg::DATA_W-1:0] o_accel_bias_x,
    output logic signed [imu_cal_pkg::DATA_W-1:0] o_accel_bias_y,
    output logic signed [imu_cal_pkg::DATA_W-1:0] o_accel_bias_z,
    output logic signed [imu_cal_pkg::DATA_W-1:0] o_gyro_bias_x,
    output logic signed [imu_cal_pkg::DATA_W-1:0] o_gyro_bias_y,
    output logic signed [imu_cal_pkg::DATA_W-1:0] o_gyro_bias_z,
    output logic                                  o_status,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [imu_cal_pkg::CFG_W-1:0]         i_cfg_sample_count
);
    import imu_cal_pkg::*;
    `include "assert_macros.svh"

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_DONE
    } t_state;

    t_state                 r_state;
    logic [COUNT_BITS-1:0]  r_cnt;
    logic [COUNT_BITS-1:0]  r_div;
    logic [STEP_W-1:0]      r_step;
    logic [CFG_W-1:0]       r_sample_count;

    logic                   in_acc;
    logic [COUNT_BITS:0]    taken;
    logic                   last;
    logic                   will_result;
    t_lane_ctl              lane_ctl;
    t_merge_ctl             merge_ctl;
    t_axis_vec              samples;
    t_axis_vec              lane_bias;
    t_axis_vec              out_bias;

    // Configuration register.
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_count <= CFG_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_sample_count <= i_cfg_sample_count;
        end
    end

    // Run bookkeeping and input acceptance.
    assign taken       = {1'b0, r_cnt} + 1'b1;
    assign last        = (taken >= {1'b0, eff_count(r_sample_count)});
    assign will_result = i_read_failed || last;
    assign o_in_ready  = (r_state == S_IDLE) && (!o_out_valid || !will_result);
    assign in_acc      = i_in_valid && o_in_ready;

    // Lane and merge control.
    always_comb begin
        lane_ctl.add    = in_acc && !i_read_failed && !last;
        lane_ctl.clear  = in_acc && i_read_failed;
        lane_ctl.start  = in_acc && !i_read_failed && last;
        lane_ctl.step   = (r_state == S_DIV);
        merge_ctl.load  = (in_acc && i_read_failed) || ((r_state == S_DONE) && !o_out_valid);
        merge_ctl.status = (r_state == S_DONE) ? STATUS_OK : STATUS_FAILED;
    end

    // Sequencer: idle, divide steps, then hand over to the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_step  <= '0;
            r_div   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_read_failed) begin
                            r_cnt <= '0;
                        end else if (last) begin
                            r_cnt   <= '0;
                            r_div   <= taken[COUNT_BITS-1:0];
                            r_step  <= '0;
                            r_state <= S_DIV;
                        end else begin
                            r_cnt <= taken[COUNT_BITS-1:0];
                        end
                    end
                end
                S_DIV: begin
                    if (r_step == STEP_W'(SUM_W - 1)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                S_DONE: begin
                    if (!o_out_valid) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Six axis lanes working side by side.
    assign samples[0] = i_accel_x;
    assign samples[1] = i_accel_y;
    assign samples[2] = i_accel_z;
    assign samples[3] = i_gyro_x;
    assign samples[4] = i_gyro_y;
    assign samples[5] = i_gyro_z;

    for (genvar g = 0; g < AXES; g++) begin : g_lane
        imu_cal_lane u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (lane_ctl),
            .i_sample  (samples[g]),
            .i_divisor (r_div),
            .o_bias    (lane_bias[g])
        );
    end

    // Result register combining the lanes.
    imu_cal_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (merge_ctl),
        .i_bias      (lane_bias),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_bias      (out_bias),
        .o_status    (o_status)
    );

    assign o_accel_bias_x = out_bias[0];
    assign o_accel_bias_y = out_bias[1];
    assign o_accel_bias_z = out_bias[2];
    assign o_gyro_bias_x  = out_bias[3];
    assign o_gyro_bias_y  = out_bias[4];
    assign o_gyro_bias_z  = out_bias[5];

    // Checks on the sequencing.
    `ASSERT_CLK(a_load_empty, merge_ctl.load |-> !o_out_valid, "result loaded over a waiting item")
    `ASSERT_CLK(a_start_div, lane_ctl.start |=> (r_state == S_DIV), "run end did not start the divider")
    `ASSERT_CLK(a_fail_clear, (in_acc && i_read_failed) |=> (r_cnt == '0), "abort left the counter set")

endmodule

[tb/imu_bias_average_calibration_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// IMU bias averaging calibration testbench
// Drives six-axis samples into the averaging block and checks every result
// item against its table value or a cycle-independent predictor of the
// per-axis sums. A short table covers the register extremes, failed reads
// and run-length changes inside a run. A full-scale partial run at the
// longest length follows, then randomized runs with stalls on both channels.
// ----------------------------------------------------------------------------
module imu_bias_average_calibration_tb;
    import imu_cal_pkg::*;

    localparam int CLK_PERIOD       = 10;
    localparam int DIVIDE_LATENCY   = SUM_W + 15;
    localparam int LONG_HOLD        = 400;
    localparam int RANDOM_ITEMS     = 1100;
    localparam int QUIET_TAIL       = 150;
    localparam int DRAIN_LIMIT      = 20000;
    localparam int FULL_RUN         = 65535;
    localparam int FULL_SCALE_ITEMS = 40;

    localparam logic signed [DATA_W-1:0] AXIS_MIN = 16'sh8000;
    localparam logic signed [DATA_W-1:0] AXIS_MAX = 16'sh7FFF;

    typedef struct packed {
        logic signed [DATA_W-1:0] accel_x;
        logic signed [DATA_W-1:0] accel_y;
        logic signed [DATA_W-1:0] accel_z;
        logic signed [DATA_W-1:0] gyro_x;
        logic signed [DATA_W-1:0] gyro_y;
        logic signed [DATA_W-1:0] gyro_z;
        logic                     read_failed;
    } t_sample;

    typedef struct packed {
        logic signed [DATA_W-1:0] accel_bias_x;
        logic signed [DATA_W-1:0] accel_bias_y;
        logic signed [DATA_W-1:0] accel_bias_z;
        logic signed [DATA_W-1:0] gyro_bias_x;
        logic signed [DATA_W-1:0] gyro_bias_y;
        logic signed [DATA_W-1:0] gyro_bias_z;
        logic                     status;
    } t_bias;

    typedef enum logic [0:0] {
        ROW_SAMPLE,
        ROW_WRITE_COUNT
    } t_row_kind;

    // One line of the directed table: a sample sent reps times, or a write.
    typedef struct packed {
        t_row_kind        kind;
        logic [CFG_W-1:0] count_value;
        logic [3:0]       reps;
        t_sample          item;
        logic             typed;
        t_bias            want;
    } t_row;

    logic             i_clk;
    logic             i_rst_n;
    logic             in_valid;
    t_sample          in_item;
    logic             out_ready;
    logic             cfg_valid;
    logic [CFG_W-1:0] cfg_data;
    logic             o_in_ready;
    logic             o_out_valid;
    logic             o_cfg_ready;
    logic signed [DATA_W-1:0] o_accel_bias_x;
    logic signed [DATA_W-1:0] o_accel_bias_y;
    logic signed [DATA_W-1:0] o_accel_bias_z;
    logic signed [DATA_W-1:0] o_gyro_bias_x;
    logic signed [DATA_W-1:0] o_gyro_bias_y;
    logic signed [DATA_W-1:0] o_gyro_bias_z;
    logic             o_status;

    // Predictor state of the block and the results it still owes.
    longint           axis_sum [AXES];
    int unsigned      samples_in_run;
    logic [CFG_W-1:0] run_length;
    t_bias            pending_biases [$];

    // Run bookkeeping.
    int  mismatch_count;
    int  samples_sent;
    int  runs_done;
    int  runs_aborted;
    int  run_length_writes;
    int  hold_requests;
    int  holds_done;
    bit  quiet_mode;
    t_row directed_rows [$];

    imu_bias_average_calibration dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (in_valid),
        .o_in_ready         (o_in_ready),
        .i_accel_x          (in_item.accel_x),
        .i_accel_y          (in_item.accel_y),
        .i_accel_z          (in_item.accel_z),
        .i_gyro_x           (in_item.gyro_x),
        .i_gyro_y           (in_item.gyro_y),
        .i_gyro_z           (in_item.gyro_z),
        .i_read_failed      (in_item.read_failed),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (out_ready),
        .o_accel_bias_x     (o_accel_bias_x),
        .o_accel_bias_y     (o_accel_bias_y),
        .o_accel_bias_z     (o_accel_bias_z),
        .o_gyro_bias_x      (o_gyro_bias_x),
        .o_gyro_bias_y      (o_gyro_bias_y),
        .o_gyro_bias_z      (o_gyro_bias_z),
        .o_status           (o_status),
        .i_cfg_valid        (cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_sample_count (cfg_data)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever begin
            #(CLK_PERIOD / 2) i_clk = ~i_clk;
        end
    end

    // Hard stop in case the block hangs.
    initial begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Adds one sample to the running sums and returns the bias item it
    // completes, if any. A failed read aborts the run with zero biases.
    task automatic average_sample(input t_sample s, output bit done, output t_bias r);
        longint      lane_in [AXES];
        longint      lane_mean [AXES];
        longint      need;
        int unsigned next_count;
        lane_in[0] = longint'(s.accel_x);
        lane_in[1] = longint'(s.accel_y);
        lane_in[2] = longint'(s.accel_z);
        lane_in[3] = longint'(s.gyro_x);
        lane_in[4] = longint'(s.gyro_y);
        lane_in[5] = longint'(s.gyro_z);
        done = 1'b1;
        r    = '0;
        if (s.read_failed) begin
            r.status = STATUS_FAILED;
        end else begin
            for (int i = 0; i < AXES; i++) begin
                axis_sum[i] += lane_in[i];
            end
            next_count = samples_in_run + 1;
            // A zero length acts as one; lengths past the counter saturate.
            need = (run_length == '0) ? 64'sd1 : longint'(run_length);
            if (need > (longint'(1) << COUNT_BITS) - 1) begin
                need = (longint'(1) << COUNT_BITS) - 1;
            end
            if (longint'(next_count) < need) begin
                samples_in_run = next_count;
                done           = 1'b0;
            end else begin
                // Division truncates toward zero, as the hardware does.
                for (int i = 0; i < AXES; i++) begin
                    lane_mean[i] = axis_sum[i] / longint'(next_count);
                end
                r.accel_bias_x = DATA_W'(lane_mean[0]);
                r.accel_bias_y = DATA_W'(lane_mean[1]);
                r.accel_bias_z = DATA_W'(lane_mean[2]);
                r.gyro_bias_x  = DATA_W'(lane_mean[3]);
                r.gyro_bias_y  = DATA_W'(lane_mean[4]);
                r.gyro_bias_z  = DATA_W'(lane_mean[5]);
                r.status       = STATUS_OK;
            end
        end
        if (done) begin
            for (int i = 0; i < AXES; i++) begin
                axis_sum[i] = 0;
            end
            samples_in_run = 0;
        end
    endtask

    // Offers one sample item, optionally after a gap, and records what it owes.
    task automatic push_sample(input t_sample item, input bit typed, input t_bias typed_want);
        bit    done;
        t_bias predicted;
        @(negedge i_clk);
        if (!quiet_mode && $urandom_range(0, 7) == 0) begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        in_item  = item;
        in_valid = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        average_sample(item, done, predicted);
        if (done) begin
            pending_biases.push_back(typed ? typed_want : predicted);
        end
        samples_sent++;
    endtask

    // Writes the run length once the block has delivered everything it owes.
    task automatic write_run_length(input logic [CFG_W-1:0] value);
        @(negedge i_clk);
        in_valid = 1'b0;
        while (pending_biases.size() != 0) @(negedge i_clk);
        repeat (DIVIDE_LATENCY) @(negedge i_clk);
        cfg_data  = value;
        cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        run_length = value;
        run_length_writes++;
        @(negedge i_clk);
        cfg_valid = 1'b0;
    endtask

    // Picks one axis reading: full scale, near zero or anything at all.
    function automatic logic signed [DATA_W-1:0] random_axis();
        logic [DATA_W-1:0] v;
        case ($urandom_range(0, 9))
            0: begin
                v = $urandom_range(0, 1) ? AXIS_MAX : AXIS_MIN;
            end
            1, 2, 3: begin
                v = DATA_W'($urandom_range(0, 1023) - 512);
            end
            default: begin
                v = DATA_W'($urandom);
            end
        endcase
        return v;
    endfunction

    function automatic t_sample random_sample(input bit allow_fail);
        t_sample s;
        s.accel_x     = random_axis();
        s.accel_y     = random_axis();
        s.accel_z     = random_axis();
        s.gyro_x      = random_axis();
        s.gyro_y      = random_axis();
        s.gyro_z      = random_axis();
        s.read_failed = allow_fail && ($urandom_range(0, 39) == 0);
        return s;
    endfunction

    task automatic check_field(input string name, input logic signed [DATA_W-1:0] want,
                               input logic signed [DATA_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // Receiver: random stalls except in quiet mode, long hold-offs on request.
    initial begin
        out_ready = 1'b0;
        holds_done = 0;
        forever begin
            @(negedge i_clk);
            if (!i_rst_n) begin
                out_ready = 1'b0;
            end else if (hold_requests != holds_done) begin
                out_ready = 1'b0;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
                holds_done++;
            end else if (!quiet_mode && $urandom_range(0, 9) == 0) begin
                out_ready = 1'b0;
                repeat ($urandom_range(1, 19) - 1) @(negedge i_clk);
            end else begin
                out_ready = 1'b1;
            end
        end
    end

    // Result checker: every accepted item against the oldest expectation.
    always @(posedge i_clk) begin
        t_bias want;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (pending_biases.size() == 0) begin
                $error("result item with no expectation waiting");
                mismatch_count++;
            end else begin
                want = pending_biases.pop_front();
                check_field("accel_bias_x", want.accel_bias_x, o_accel_bias_x);
                check_field("accel_bias_y", want.accel_bias_y, o_accel_bias_y);
                check_field("accel_bias_z", want.accel_bias_z, o_accel_bias_z);
                check_field("gyro_bias_x", want.gyro_bias_x, o_gyro_bias_x);
                check_field("gyro_bias_y", want.gyro_bias_y, o_gyro_bias_y);
                check_field("gyro_bias_z", want.gyro_bias_z, o_gyro_bias_z);
                check_field("status", {{(DATA_W-1){1'b0}}, want.status},
                            {{(DATA_W-1){1'b0}}, o_status});
            end
            if (o_status == STATUS_FAILED) begin
                runs_aborted++;
            end else begin
                runs_done++;
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        t_sample          s;
        logic [CFG_W-1:0] count_sel;
        int               n;
        int               random_items;
        int               drain_cycles;

        i_rst_n           = 1'b0;
        in_valid          = 1'b0;
        in_item           = '0;
        cfg_valid         = 1'b0;
        cfg_data          = '0;
        quiet_mode        = 1'b0;
        mismatch_count    = 0;
        samples_sent      = 0;
        runs_done         = 0;
        runs_aborted      = 0;
        run_length_writes = 0;
        hold_requests     = 0;
        random_items      = 0;
        samples_in_run    = 0;
        run_length        = CFG_RESET;
        for (int i = 0; i < AXES; i++) begin
            axis_sum[i] = 0;
        end

        // Directed table. Typed results are the obvious ones; the rest are
        // checked against the predictor.
        // Failed read right after reset: values are ignored.
        directed_rows.push_back('{ROW_SAMPLE, 16'd0, 4'd1,
            '{16'sh1234, 16'sh8001, 16'sh7FFE, 16'shFFFF, 16'sh5555, 16'shAAAA, 1'b1},
            1'b1, '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, STATUS_FAILED}});
        // Run of the reset length, constant readings average to themselves.
        directed_rows.push_back('{ROW_SAMPLE, 16'd0, 4'd10,
            '{AXIS_MAX, AXIS_MIN, 16'sd1, -16'sd1, 16'sd0, -16'sd12345, 1'b0},
            1'b1, '{AXIS_MAX, AXIS_MIN, 16'sd1, -16'sd1, 16'sd0, -16'sd12345, STATUS_OK}});
        directed_rows.push_back('{ROW_WRITE_COUNT, 16'd1, 4'd0, '0, 1'b0, '0});
        directed_rows.push_back('{ROW_SAMPLE, 16'd0, 4'd1,
            '{AXIS_MIN, AXIS_MIN, AXIS_MIN, AXIS_MIN, AXIS_MIN, AXIS_MIN, 1'b0},
            1'b1, '{AXIS_MIN, AXIS_MIN, AXIS_MIN, AXIS_MIN, AXIS_MIN, AXIS_MIN, STATUS_OK}});
        // A zero run length behaves as one.
        directed_rows.push_back('{ROW_WRITE_COUNT, 16'd0, 4'd0, '0, 1'b0, '0});
        directed_rows.push_back('{ROW_SAMPLE, 16'd0, 4'd1,
            '{AXIS_MAX, AXIS_MAX, AXIS_MAX, AXIS_MAX, AXIS_MAX, AXIS_MAX, 1'b0},
            1'b1, '{AXIS_MAX, AXIS_MAX, AXIS_MAX, AXIS_MAX, AXIS_MAX, AXIS_MAX, STATUS_OK}});
        // Odd sums of two: truncation toward zero on both signs.
        directed_rows.push_back('{ROW_WRITE_COUNT, 16'd2, 4'd0, '0, 1'b0, '0});
        directed_rows.push_back('{ROW_SAMPLE, 16'd0, 4'd1,
            '{AXIS_MIN, AXIS_MIN, AXIS_MAX, AXIS_MAX, -16'sd3, 16'sd3, 1'b0}, 1'b0, '0});
        directed_rows.push_back('{ROW_SAMPLE, 16'd0, 4'd1,
            '{-16'sd32767, AXIS_MAX, 16'sd32766, AXIS_MIN, 16'sd0, 16'sd0, 1'b0}, 1'b0, '0});
        directed_rows.push_back('{ROW_SAMPLE, 16'd0, 4'd1,
            '{16'sd3, -16'sd3, 16'sd1, -16'sd1, 16'sd0, 16'sd5, 1'b0}, 1'b0, '0});
        directed_rows.push_back('{ROW_SAMPLE, 16'd0, 4'd1,
            '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0}, 1'b0, '0});
        // Failed read in the middle of a run, then a clean restart.
        directed_rows.push_back('{ROW_WRITE_COUNT, 16'd3, 4'd0, '0, 1'b0, '0});
        directed_rows.push_back('{ROW_SAMPLE, 16'd0, 4'd1,
            '{16'sd100, -16'sd100, 16'sd200, -16'sd200, 16'sd300, -16'sd300, 1'b0},
            1'b0, '0});
        directed_rows.push_back('{ROW_SAMPLE, 16'd0, 4'd1,
            '{AXIS_MAX, AXIS_MAX, AXIS_MAX, AXIS_MIN, AXIS_MIN, AXIS_MIN, 1'b1},
            1'b1, '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, STATUS_FAILED}});
        directed_rows.push_back('{ROW_SAMPLE, 16'd0, 4'd3,
            '{-16'sd7, 16'sd7, -16'sd8, 16'sd8, AXIS_MIN, AXIS_MAX, 1'b0}, 1'b0, '0});
        // Run length lowered below the samples already taken.
        directed_rows.push_back('{ROW_SAMPLE, 16'd0, 4'd2,
            '{16'sd1000, -16'sd1000, 16'sd7, -16'sd7, AXIS_MAX, AXIS_MIN, 1'b0}, 1'b0, '0});
        directed_rows.push_back('{ROW_WRITE_COUNT, 16'd1, 4'd0, '0, 1'b0, '0});
        directed_rows.push_back('{ROW_SAMPLE, 16'd0, 4'd1,
            '{-16'sd999, 16'sd999, 16'sd1, 16'sd1, AXIS_MAX, AXIS_MIN, 1'b0}, 1'b0, '0});

        // Synchronous reset.
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_WRITE_COUNT) begin
                write_run_length(directed_rows[r].count_value);
            end else begin
                repeat (directed_rows[r].reps) begin
                    push_sample(directed_rows[r].item, directed_rows[r].typed,
                                directed_rows[r].want);
                end
            end
        end

        // Back pressure: the receiver holds off while every item makes a
        // result, so the output register fills and the input stalls.
        write_run_length(16'd1);
        quiet_mode = 1'b1;
        hold_requests++;
        repeat (40) begin
            push_sample(random_sample(1'b1), 1'b0, '0);
        end
        quiet_mode = 1'b0;

        // Longest run length with full-scale readings on two axes, so the
        // sums grow well past the sample width; the length is then lowered
        // and the next sample ends the partial run.
        write_run_length(16'(FULL_RUN));
        quiet_mode = 1'b1;
        repeat (FULL_SCALE_ITEMS) begin
            s         = random_sample(1'b0);
            s.accel_x = AXIS_MIN;
            s.gyro_z  = AXIS_MAX;
            push_sample(s, 1'b0, '0);
        end
        quiet_mode = 1'b0;
        write_run_length(16'd1);
        s         = random_sample(1'b0);
        s.accel_x = AXIS_MIN;
        s.gyro_z  = AXIS_MAX;
        push_sample(s, 1'b0, '0);

        // Random runs; mostly short lengths, partial runs carry across writes.
        while (random_items < RANDOM_ITEMS) begin
            case ($urandom_range(0, 19)) inside
                [0:9]:   count_sel = CFG_W'($urandom_range(1, 4));
                [10:14]: count_sel = CFG_W'($urandom_range(5, 16));
                [15:17]: count_sel = CFG_W'($urandom_range(17, 64));
                18:      count_sel = '0;
                default: count_sel = CFG_W'(1);
            endcase
            write_run_length(count_sel);
            n = (count_sel == '0) ? $urandom_range(1, 4)
                : int'(count_sel) * $urandom_range(1, 3) + $urandom_range(0, count_sel - 1);
            for (int i = 0; i < n; i++) begin
                if (random_items >= RANDOM_ITEMS - QUIET_TAIL) begin
                    quiet_mode = 1'b1;
                end
                push_sample(random_sample(1'b1), 1'b0, '0);
                random_items++;
            end
        end

        // Drain and let the divider settle before judging.
        @(negedge i_clk);
        in_valid = 1'b0;
        drain_cycles = 0;
        while (pending_biases.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
            @(negedge i_clk);
            drain_cycles++;
        end
        repeat (DIVIDE_LATENCY) @(negedge i_clk);
        if (pending_biases.size() != 0) begin
            $error("%0d result items never arrived", pending_biases.size());
            mismatch_count++;
        end

        $display("Sent %0d samples; %0d runs completed and %0d aborted by read failures.",
                 samples_sent, runs_done, runs_aborted);
        $display("Run length written %0d times, including 0, 1 and %0d.",
                 run_length_writes, FULL_RUN);
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
